/* rtl/bcsf_pkg.sv */
// shared types, constants and helper functions of the byte class stream fingerprint
`timescale 1ns / 1ps
package bcsf_pkg;

  // default width of the byte counter
  localparam int LENGTH_BITS_DEFAULT = 32;

  // request queue between classifier and hash engine
  localparam int QUEUE_DEPTH = 2;

  // hash constants
  localparam logic [63:0] HASH_SEED = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] FMIX_C1   = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_C2   = 64'hc4ceb9fe1a85ec53;
  localparam int          FMIX_SHIFT = 33;
  localparam int          HASH_ROT   = 7;

  // byte classes
  localparam logic [2:0] CLASS_LETTER    = 3'd0;
  localparam logic [2:0] CLASS_DIGIT     = 3'd1;
  localparam logic [2:0] CLASS_SPACE     = 3'd2;
  localparam logic [2:0] CLASS_PRINTABLE = 3'd3;
  localparam logic [2:0] CLASS_OTHER     = 3'd4;
  localparam logic [2:0] NO_CLASS        = 3'd7;

  // result field layout in the output word, lowest bit first
  localparam int FP_W      = 64;
  localparam int LEN_W     = 32;
  localparam int MASK_W    = 5;
  localparam int CHG_W     = 8;
  localparam int VERDICT_W = 2;
  localparam int LEN_LSB     = FP_W;
  localparam int MASK_LSB    = LEN_LSB + LEN_W;
  localparam int CHG_LSB     = MASK_LSB + MASK_W;
  localparam int VERDICT_LSB = CHG_LSB + CHG_W;
  localparam int OUT_USED_W  = VERDICT_LSB + VERDICT_W;
  localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    VERDICT_VALID,
    VERDICT_AMBIGUOUS,
    VERDICT_BROKEN
  } verdict_t;

  // one request from the classifier to the hash engine
  typedef struct packed {
    logic [63:0]       mix;
    logic [63:0]       length;
    logic [MASK_W-1:0] mask;
    logic [CHG_W-1:0]  changes;
    verdict_t          verdict;
    logic              last;
    logic              empty;
  } entry_t;

  // class of one byte
  function automatic logic [2:0] byte_class(input logic [7:0] b);
    logic [2:0] c;
    if ((b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a)) begin
      c = CLASS_LETTER;
    end else if (b >= 8'h30 && b <= 8'h39) begin
      c = CLASS_DIGIT;
    end else if (b == 8'h20 || b == 8'h09 || b == 8'h0a || b == 8'h0d) begin
      c = CLASS_SPACE;
    end else if (b >= 8'h20 && b <= 8'h7e) begin
      c = CLASS_PRINTABLE;
    end else begin
      c = CLASS_OTHER;
    end
    return c;
  endfunction

  // xor-shift step of the finalizer
  function automatic logic [63:0] fmix_xs(input logic [63:0] v);
    return v ^ (v >> FMIX_SHIFT);
  endfunction

  // rotate left of the rolling hash
  function automatic logic [63:0] hash_rotl(input logic [63:0] v);
    return (v << HASH_ROT) | (v >> (64 - HASH_ROT));
  endfunction

endpackage

/* rtl/bcsf_front.sv */
// classifier front end: byte class, frame statistics and per-byte mix word
`timescale 1ns / 1ps
module bcsf_front #(
  parameter int LENGTH_BITS = bcsf_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  input  logic             empty_frame,
  output bcsf_pkg::entry_t entry
);

  logic [LENGTH_BITS-1:0]       idx_r;
  logic                         over_r;
  logic                         zero_r;
  logic [bcsf_pkg::MASK_W-1:0]  mask_r;
  logic [bcsf_pkg::CHG_W-1:0]   chg_r;
  logic [2:0]                   prev_r;

  logic [2:0]                   cls;
  logic                         at_max;
  logic [LENGTH_BITS-1:0]       idx_nxt;
  logic                         over_nxt;
  logic                         zero_nxt;
  logic [bcsf_pkg::MASK_W-1:0]  mask_nxt;
  logic [bcsf_pkg::CHG_W-1:0]   chg_nxt;
  logic [63:0]                  mix;
  bcsf_pkg::verdict_t           verdict;

  // per-byte statistics and mix word
  always_comb begin
    cls      = bcsf_pkg::byte_class(data_byte);
    at_max   = &idx_r;
    idx_nxt  = at_max ? idx_r : idx_r + LENGTH_BITS'(1);
    over_nxt = over_r | at_max;
    zero_nxt = zero_r | (data_byte == 8'h00);
    mask_nxt = mask_r | (bcsf_pkg::MASK_W'(1) << cls);
    chg_nxt  = chg_r + bcsf_pkg::CHG_W'(prev_r != bcsf_pkg::NO_CLASS && prev_r != cls);
    mix      = {5'b0, cls, idx_r[7:0], 40'b0, data_byte} + 64'(idx_r) + 64'd1;
  end

  // verdict on the frame closed by this byte
  always_comb begin
    if ((zero_nxt && idx_nxt > LENGTH_BITS'(1)) || over_nxt) begin
      verdict = bcsf_pkg::VERDICT_BROKEN;
    end else if (chg_nxt <= bcsf_pkg::CHG_W'(1) ||
                 (mask_nxt & (mask_nxt - bcsf_pkg::MASK_W'(1))) == '0) begin
      verdict = bcsf_pkg::VERDICT_AMBIGUOUS;
    end else begin
      verdict = bcsf_pkg::VERDICT_VALID;
    end
  end

  // request to the hash engine
  always_comb begin
    if (empty_frame) begin
      entry.mix     = '0;
      entry.length  = '0;
      entry.mask    = '0;
      entry.changes = '0;
      entry.verdict = bcsf_pkg::VERDICT_AMBIGUOUS;
      entry.last    = 1'b1;
      entry.empty   = 1'b1;
    end else begin
      entry.mix     = mix;
      entry.length  = 64'(idx_nxt);
      entry.mask    = mask_nxt;
      entry.changes = chg_nxt;
      entry.verdict = verdict;
      entry.last    = last_byte;
      entry.empty   = 1'b0;
    end
  end

  // frame state, cleared at the end of every frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      over_r <= 1'b0;
      zero_r <= 1'b0;
      mask_r <= '0;
      chg_r  <= '0;
      prev_r <= bcsf_pkg::NO_CLASS;
    end else if (accept) begin
      if (empty_frame || last_byte) begin
        idx_r  <= '0;
        over_r <= 1'b0;
        zero_r <= 1'b0;
        mask_r <= '0;
        chg_r  <= '0;
        prev_r <= bcsf_pkg::NO_CLASS;
      end else begin
        idx_r  <= idx_nxt;
        over_r <= over_nxt;
        zero_r <= zero_nxt;
        mask_r <= mask_nxt;
        chg_r  <= chg_nxt;
        prev_r <= cls;
      end
    end
  end

endmodule

/* rtl/bcsf_queue.sv */
// short request queue between classifier and hash engine
`timescale 1ns / 1ps
module bcsf_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  bcsf_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output bcsf_pkg::entry_t pop_data,
  output logic             not_empty
);

  localparam int DEPTH = bcsf_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bcsf_pkg::entry_t   slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* rtl/bcsf_hash.sv */
// hash engine: 64-bit finalizer on a shared 32x32 multiplier and the rolling hash
`timescale 1ns / 1ps
module bcsf_hash (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_valid,
  input  bcsf_pkg::entry_t                      q_data,
  output logic                                  q_pop,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [bcsf_pkg::OUT_DATA_W-1:0]       out_data
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_FOLD, S_OUT} state_t;
  typedef enum logic [1:0] {MIX_DATA, MIX_LEN, MIX_STATS} mix_t;

  state_t                          state_r;
  mix_t                            stage_r;
  bcsf_pkg::entry_t                ent_r;
  logic [63:0]                     hash_r;
  logic [63:0]                     v_r;
  logic [63:0]                     acc_r;
  logic [63:0]                     prod_r;
  logic [1:0]                      mstep_r;
  logic                            cidx_r;
  logic                            out_valid_r;
  logic [bcsf_pkg::FP_W-1:0]       fp_r;
  logic [bcsf_pkg::LEN_W-1:0]      len_r;
  logic [bcsf_pkg::MASK_W-1:0]     mask_r;
  logic [bcsf_pkg::CHG_W-1:0]      chg_r;
  bcsf_pkg::verdict_t              verdict_r;

  logic [63:0] mul_c;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [63:0] mul_res;
  logic        out_free;

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = {{(bcsf_pkg::OUT_DATA_W - bcsf_pkg::OUT_USED_W){1'b0}},
                      verdict_r, chg_r, mask_r, len_r, fp_r};

  // partial product select: lo*lo, hi*lo, lo*hi
  always_comb begin
    mul_c   = cidx_r ? bcsf_pkg::FMIX_C2 : bcsf_pkg::FMIX_C1;
    mul_a   = (mstep_r == 2'd1) ? v_r[63:32] : v_r[31:0];
    mul_b   = (mstep_r == 2'd2) ? mul_c[63:32] : mul_c[31:0];
    prod    = 64'(mul_a) * 64'(mul_b);
    mul_res = acc_r + {prod_r[31:0], 32'b0};
  end

  // sequencer, hash state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stage_r     <= MIX_DATA;
      hash_r      <= bcsf_pkg::HASH_SEED;
      mstep_r     <= '0;
      cidx_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // result valid: set on hand-over, cleared when taken
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        // take the next request
        S_IDLE: begin
          if (q_valid) begin
            ent_r <= q_data;
            if (q_data.empty) begin
              state_r <= S_OUT;
            end else begin
              v_r     <= bcsf_pkg::fmix_xs(q_data.mix);
              stage_r <= MIX_DATA;
              cidx_r  <= 1'b0;
              mstep_r <= '0;
              state_r <= S_MUL;
            end
          end
        end
        // one 64-bit multiply in four steps, two per finalizer
        S_MUL: begin
          case (mstep_r)
            2'd0: begin
              prod_r  <= prod;
              mstep_r <= 2'd1;
            end
            2'd1: begin
              acc_r   <= prod_r;
              prod_r  <= prod;
              mstep_r <= 2'd2;
            end
            2'd2: begin
              acc_r   <= mul_res;
              prod_r  <= prod;
              mstep_r <= 2'd3;
            end
            default: begin
              v_r     <= bcsf_pkg::fmix_xs(mul_res);
              mstep_r <= 2'd0;
              if (cidx_r) begin
                state_r <= S_FOLD;
              end else begin
                cidx_r <= 1'b1;
              end
            end
          endcase
        end
        // fold the finalized word into the hash
        S_FOLD: begin
          cidx_r <= 1'b0;
          case (stage_r)
            MIX_DATA: begin
              hash_r <= bcsf_pkg::hash_rotl(hash_r ^ v_r);
              if (ent_r.last) begin
                v_r     <= bcsf_pkg::fmix_xs(ent_r.length);
                stage_r <= MIX_LEN;
                state_r <= S_MUL;
              end else begin
                state_r <= S_IDLE;
              end
            end
            MIX_LEN: begin
              hash_r  <= hash_r ^ v_r;
              v_r     <= bcsf_pkg::fmix_xs({43'b0, ent_r.mask, 8'b0, ent_r.changes});
              stage_r <= MIX_STATS;
              state_r <= S_MUL;
            end
            default: begin
              hash_r  <= hash_r ^ v_r;
              state_r <= S_OUT;
            end
          endcase
        end
        // hand over the result and restart the hash
        default: begin
          if (out_free) begin
            fp_r        <= ent_r.empty ? '0 : hash_r;
            len_r       <= ent_r.length[bcsf_pkg::LEN_W-1:0];
            mask_r      <= ent_r.mask;
            chg_r       <= ent_r.changes;
            verdict_r   <= ent_r.verdict;
            hash_r      <= bcsf_pkg::HASH_SEED;
            state_r     <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

/* rtl/byte_class_stream_fingerprint.sv */
// top level of the byte class stream fingerprint
`timescale 1ns / 1ps
// Fingerprints frames that arrive one byte per request. A classifier takes a
// byte in every cycle while its two-entry request queue has room; the hash
// engine behind it finalizes each byte's mix word with two 64-bit multiplies,
// each built from three 32x32 partial products on one shared multiplier plus
// a closing add. The hash engine takes no new byte until it has folded the
// last one into the hash; a last byte also needs two more finalizer passes
// for length and statistics and the result hand-over, and an empty frame
// goes straight to the hand-over. The result sits in an output register,
// so the next frame's bytes are taken while it waits.
module byte_class_stream_fingerprint #(
  parameter int LENGTH_BITS = bcsf_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] data_byte
  input  logic                                in_tlast,   // last_byte
  input  logic                                in_tuser,   // empty_frame
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [63:0] fingerprint, [95:64] frame_length, [100:96] classes_seen,
  // [108:101] class_changes, [110:109] verdict, [111] zero
  output logic [bcsf_pkg::OUT_DATA_W-1:0]     out_tdata
);

  bcsf_pkg::entry_t front_entry;
  bcsf_pkg::entry_t q_data;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  logic             accept;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // classifier
  bcsf_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .data_byte   (in_tdata),
    .last_byte   (in_tlast),
    .empty_frame (in_tuser),
    .entry       (front_entry)
  );

  // request queue
  bcsf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (front_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .not_empty (q_valid)
  );

  // hash engine
  bcsf_hash u_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

/* rtl/bcsf_checker.sv */
// port-level checks of the byte class stream fingerprint and their binding
`timescale 1ns / 1ps
module bcsf_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [bcsf_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic [bcsf_pkg::VERDICT_W-1:0] verdict;
  logic [bcsf_pkg::MASK_W-1:0]    classes;
  logic [bcsf_pkg::CHG_W-1:0]     changes;

  assign verdict = out_tdata[bcsf_pkg::VERDICT_LSB +: bcsf_pkg::VERDICT_W];
  assign classes = out_tdata[bcsf_pkg::MASK_LSB +: bcsf_pkg::MASK_W];
  assign changes = out_tdata[bcsf_pkg::CHG_LSB +: bcsf_pkg::CHG_W];

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result shown after reset");

  // a stalled result stays
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // a valid verdict needs two classes and two changes
  a_valid_rich: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && verdict == bcsf_pkg::VERDICT_VALID |->
      $countones(classes) >= 2 && changes >= bcsf_pkg::CHG_W'(2))
    else $error("valid verdict on a poor frame");

  // verdict code in range
  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> verdict == bcsf_pkg::VERDICT_VALID ||
                   verdict == bcsf_pkg::VERDICT_AMBIGUOUS ||
                   verdict == bcsf_pkg::VERDICT_BROKEN)
    else $error("unknown verdict code");

endmodule

bind byte_class_stream_fingerprint bcsf_checker u_bcsf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
